// File: sv/multichannel_servo_pulse_generator_macros.svh
// assertion macros used by the checker of the servo pulse generator
`ifndef MULTICHANNEL_SERVO_PULSE_GENERATOR_MACROS_SVH
`define MULTICHANNEL_SERVO_PULSE_GENERATOR_MACROS_SVH

// implication in the same cycle, off while reset is asserted
`define MSPG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, off while reset is asserted
`define MSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after reset was seen
`define MSPG_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mspg_pkg.sv
package mspg_pkg;

    // parameter defaults
    localparam int DEF_FULL_STEPS   = 255;
    localparam int DEF_NUM_CHANNELS = 2;

    // field widths
    localparam int MODE_W     = 2;
    localparam int POS_W      = 8;
    localparam int ANG_W      = 8;
    localparam int CENTRE_W   = 8;
    localparam int MASK_W     = 2;
    localparam int TICS_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // degrees covered by the full position range
    localparam int ANGLE_SPAN = 180;

    // register reset values
    localparam logic [TICS_W-1:0]   RST_PERIOD  = 16'd1250;
    localparam logic [MASK_W-1:0]   RST_REVERSE = 2'd0;
    localparam logic [TICS_W-1:0]   RST_MIN     = 16'd59;
    localparam logic [TICS_W-1:0]   RST_MAX     = 16'd128;
    localparam logic [CENTRE_W-1:0] RST_CENTRE  = 8'd127;

    typedef enum logic [MODE_W-1:0] {
        MODE_POSITION = 2'd0,
        MODE_ANGLE    = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_NOP      = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD  = 3'd0,
        CFG_REVERSE = 3'd1,
        CFG_MIN0    = 3'd2,
        CFG_MAX0    = 3'd3,
        CFG_CENTRE0 = 3'd4,
        CFG_MIN1    = 3'd5,
        CFG_MAX1    = 3'd6,
        CFG_CENTRE1 = 3'd7
    } t_cfg_idx;

    // control that travels with an item down the pipeline
    typedef struct packed {
        t_mode mode;
        logic  ch;
    } t_ctl;

endpackage

// File: sv/multichannel_servo_pulse_generator.sv
// Two-channel RC servo pulse sequencer.
// Input channel (i_valid / o_stall): one item per transfer. Mode 0 sets a
// channel position, mode 1 sets it as an angle, mode 2 is a compare tick,
// mode 3 does nothing. Every item gives exactly one result.
// Output channel (o_valid / i_stall): pin mask, interval to the next compare
// (ticks only) and stored duty (set items only).
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index at
// the clock edge; write only while no item is in flight.
// An item passes through pipeline registers r0 to r7 and the output register. The
// path is an 8 stage pipeline whose depth is set by the chain of constant
// reciprocal multiplies (angle scaling, then the split divide by full steps).
// Throughput: one item per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall follows i_stall; items in flight are kept, none are lost.
// Reset (synchronous, active low) empties the pipeline, loads register
// defaults and clears slot, elapsed count, pulse widths and pins; o_stall is
// high during reset.
module multichannel_servo_pulse_generator
    import mspg_pkg::*;
#(
    parameter int FULL_STEPS   = DEF_FULL_STEPS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic                  i_channel,
    input  logic [POS_W-1:0]      i_position,
    input  logic [ANG_W-1:0]      i_angle_deg,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [MASK_W-1:0]     o_pin_mask,
    output logic [TICS_W-1:0]     o_next_interval,
    output logic [TICS_W-1:0]     o_duty_value
);

    // widths and reciprocal constants derived from the step count
    localparam int SW       = $clog2(FULL_STEPS + 1);
    localparam int LS       = $clog2(FULL_STEPS);
    localparam int HALF     = FULL_STEPS / 2;
    localparam int APW      = ANG_W + SW;
    localparam int ANG_L    = $clog2(ANGLE_SPAN);
    localparam longint M180_L =
        ((longint'(1) << (APW + ANG_L)) + ANGLE_SPAN - 1) / ANGLE_SPAN;
    localparam int M180W    = $clog2(M180_L + 1);
    localparam int AFW      = APW + M180W;
    localparam int POSA_W   = $clog2((((1 << ANG_W) - 1) * FULL_STEPS) / ANGLE_SPAN + 1);
    localparam int PSW      = (POSA_W > POS_W) ? POSA_W : POS_W;
    localparam longint MA_L =
        ((longint'(1) << (TICS_W + LS)) + FULL_STEPS - 1) / FULL_STEPS;
    localparam int MAW      = $clog2(MA_L + 1);
    localparam int QPW      = TICS_W + MAW;
    localparam int QAW      = $clog2(((1 << TICS_W) - 1) / FULL_STEPS + 1);
    localparam int RAW      = LS;
    localparam int BW       = TICS_W + 1;
    localparam int TW       = RAW + BW;
    localparam longint MR_L =
        ((longint'(1) << (TW + LS)) + FULL_STEPS - 1) / FULL_STEPS;
    localparam int MRW      = $clog2(MR_L + 1);
    localparam int RPW      = TW + MRW;
    localparam int CNW      = TICS_W + 6;
    localparam int NSTG     = 8;

    localparam logic [SW-1:0]           STEPS     = SW'(FULL_STEPS);
    localparam logic [TICS_W-1:0]       HALF_T    = TICS_W'(HALF);
    localparam logic [M180W-1:0]        M180      = M180W'(M180_L);
    localparam logic [MAW-1:0]          MA        = MAW'(MA_L);
    localparam logic [MRW-1:0]          MR        = MRW'(MR_L);
    localparam logic [2:0]              NC3       = 3'(NUM_CHANNELS);
    localparam logic signed [CNW-1:0]   EIGHT_S   = CNW'(8 * FULL_STEPS);
    localparam logic signed [CNW-1:0]   DIV_BIAS  = CNW'(15);
    localparam logic signed [CNW-1:0]   ZERO_S    = CNW'(0);

    // configuration registers
    logic [TICS_W-1:0]   r_period;
    logic [MASK_W-1:0]   r_rev;
    logic [TICS_W-1:0]   r_min [0:1];
    logic [TICS_W-1:0]   r_max [0:1];
    logic [CENTRE_W-1:0] r_mid [0:1];
    logic [TICS_W-1:0]   r_centre [0:1];

    // block state
    logic [1:0]          r_slot;
    logic [TICS_W-1:0]   r_elapsed;
    logic [TICS_W-1:0]   r_pw [0:1];
    logic [MASK_W-1:0]   r_pins;

    // pipeline control
    logic                r_vld [0:NSTG-1];
    t_ctl                r_ctl [0:NSTG-1];
    logic                en;

    // pipeline payload
    logic [POS_W-1:0]    r0_position;
    logic [ANG_W-1:0]    r0_angle;
    logic [POS_W-1:0]    r1_position;
    logic [APW-1:0]      r1_ang_prod;
    logic [PSW-1:0]      r2_pos;
    logic [TICS_W-1:0]   r3_a, r4_a;
    logic [TICS_W-1:0]   r3_base, r4_base, r5_base, r6_base, r7_base;
    logic                r3_neg, r4_neg, r5_neg, r6_neg, r7_neg;
    logic [BW-1:0]       r3_bmag, r4_bmag, r5_bmag;
    logic [QAW-1:0]      r4_qa;
    logic [RAW-1:0]      r5_ra;
    logic [TICS_W-1:0]   r5_p1, r6_p1;
    logic [TW-1:0]       r6_t;
    logic [TICS_W-1:0]   r7_q;

    // output register
    logic                r_out_vld;
    logic [MASK_W-1:0]   r_pin_mask;
    logic [TICS_W-1:0]   r_interval;
    logic [TICS_W-1:0]   r_duty;

    // stage logic
    logic [APW-1:0]          ang_prod;
    logic [AFW-1:0]          ang_full;
    logic [PSW-1:0]          pos_ang;
    logic [PSW-1:0]          n_pos;
    logic signed [CNW-1:0]   cen_num [0:1];
    logic signed [CNW-1:0]   cen_div [0:1];
    logic [TICS_W-1:0]       n_centre [0:1];
    logic [TICS_W-1:0]       s3_lo, s3_hi, s3_c, p16, n_a, n_base;
    logic                    s3_rev, lo_half;
    logic [BW-1:0]           diff, mag;
    logic [QPW-1:0]          qa_full;
    logic [TICS_W-1:0]       qa_s;
    logic [RPW-1:0]          q2_full;
    logic [TICS_W-1:0]       q2;
    logic [TICS_W-1:0]       w_raw, w_lo, w_clamp, s8_min, s8_max;
    logic                    ch_ok;
    logic [2:0]              s_cur, s_nxt;
    logic [TICS_W-1:0]       gap, el_sum;
    logic [1:0]              n_slot;
    logic [TICS_W-1:0]       n_elapsed, n_interval, n_duty;
    logic [MASK_W-1:0]       n_pins;

    // whole pipeline moves when the output register is free or being taken
    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en || !i_rst_n;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PERIOD;
            r_rev    <= RST_REVERSE;
            r_min[0] <= RST_MIN;
            r_max[0] <= RST_MAX;
            r_mid[0] <= RST_CENTRE;
            r_min[1] <= RST_MIN;
            r_max[1] <= RST_MAX;
            r_mid[1] <= RST_CENTRE;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD:  r_period <= i_cfg_data;
                CFG_REVERSE: r_rev    <= i_cfg_data[MASK_W-1:0];
                CFG_MIN0:    r_min[0] <= i_cfg_data;
                CFG_MAX0:    r_max[0] <= i_cfg_data;
                CFG_CENTRE0: r_mid[0] <= i_cfg_data[CENTRE_W-1:0];
                CFG_MIN1:    r_min[1] <= i_cfg_data;
                CFG_MAX1:    r_max[1] <= i_cfg_data;
                CFG_CENTRE1: r_mid[1] <= i_cfg_data[CENTRE_W-1:0];
            endcase
        end
    end

    // centre point per channel, signed divide by 16 rounding toward zero
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            cen_num[c] = ((CNW'(signed'({1'b0, r_max[c]}))
                         - CNW'(signed'({1'b0, r_min[c]}))) <<< 3)
                       + (CNW'(signed'({1'b0, r_mid[c]})) <<< 4) - EIGHT_S;
            cen_div[c] = (cen_num[c] + (cen_num[c][CNW-1] ? DIV_BIAS : ZERO_S)) >>> 4;
            n_centre[c] = cen_div[c][TICS_W-1:0] + r_min[c];
        end
    end

    always_ff @(posedge i_clk) begin
        r_centre[0] <= n_centre[0];
        r_centre[1] <= n_centre[1];
    end

    // stage 1: angle times full steps
    assign ang_prod = APW'(r0_angle) * APW'(STEPS);

    // stage 2: divide by the angle span through its reciprocal
    assign ang_full = AFW'(r1_ang_prod) * AFW'(M180);
    assign pos_ang  = PSW'(ang_full >> (APW + ANG_L));
    assign n_pos    = (r_ctl[1].mode == MODE_ANGLE) ? pos_ang : PSW'(r1_position);

    // stage 3: reverse, pick the half and the slope operands
    always_comb begin
        s3_lo   = r_min[r_ctl[2].ch];
        s3_hi   = r_max[r_ctl[2].ch];
        s3_c    = r_centre[r_ctl[2].ch];
        s3_rev  = r_rev[r_ctl[2].ch];
        p16     = s3_rev ? (TICS_W'(STEPS) - TICS_W'(r2_pos)) : TICS_W'(r2_pos);
        lo_half = p16 < HALF_T;
        n_a     = lo_half ? p16 : (p16 - HALF_T);
        n_base  = lo_half ? s3_lo : s3_c;
        diff    = lo_half ? ({1'b0, s3_c} - {1'b0, s3_lo})
                          : ({1'b0, s3_hi} - {1'b0, s3_c});
        mag     = diff[BW-1] ? (BW'(0) - diff) : diff;
    end

    // stage 4: whole steps of the offset
    assign qa_full = QPW'(r3_a) * QPW'(MA);

    // stage 5: remainder and the whole-step share of the product
    assign qa_s = TICS_W'(r4_qa) * TICS_W'(STEPS);

    // stage 7: remainder share of the product divided by full steps
    assign q2_full = RPW'(r6_t) * RPW'(MR);
    assign q2      = TICS_W'(q2_full >> (TW + LS));

    // pipeline valid and control shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0]    <= '{mode: t_mode'(i_mode), ch: i_channel};
            for (int k = 1; k < NSTG; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r0_position <= i_position;
            r0_angle    <= i_angle_deg;
            r1_position <= r0_position;
            r1_ang_prod <= ang_prod;
            r2_pos      <= n_pos;
            r3_a        <= n_a;
            r3_base     <= n_base;
            r3_neg      <= diff[BW-1];
            r3_bmag     <= {mag[TICS_W-1:0], 1'b0};
            r4_a        <= r3_a;
            r4_base     <= r3_base;
            r4_neg      <= r3_neg;
            r4_bmag     <= r3_bmag;
            r4_qa       <= QAW'(qa_full >> (TICS_W + LS));
            r5_base     <= r4_base;
            r5_neg      <= r4_neg;
            r5_bmag     <= r4_bmag;
            r5_ra       <= RAW'(r4_a - qa_s);
            r5_p1       <= TICS_W'(r4_qa) * r4_bmag[TICS_W-1:0];
            r6_base     <= r5_base;
            r6_neg      <= r5_neg;
            r6_p1       <= r5_p1;
            r6_t        <= TW'(r5_ra) * TW'(r5_bmag);
            r7_base     <= r6_base;
            r7_neg      <= r6_neg;
            r7_q        <= r6_p1 + q2;
        end
    end

    // stage 8: clamp the width, run the tick sequencer
    always_comb begin
        s8_min     = r_min[r_ctl[7].ch];
        s8_max     = r_max[r_ctl[7].ch];
        w_raw      = r7_neg ? (r7_base - r7_q) : (r7_base + r7_q);
        w_lo       = (w_raw < s8_min) ? s8_min : w_raw;
        w_clamp    = (w_lo > s8_max) ? s8_max : w_lo;
        ch_ok      = {2'b00, r_ctl[7].ch} < NC3;
        s_cur      = {1'b0, r_slot};
        s_nxt      = s_cur + 3'd1;
        gap        = r_period - r_elapsed;
        el_sum     = r_elapsed;
        n_slot     = r_slot;
        n_elapsed  = r_elapsed;
        n_pins     = r_pins;
        n_interval = '0;
        n_duty     = '0;
        unique case (r_ctl[7].mode)
            MODE_POSITION, MODE_ANGLE: begin
                if (ch_ok) begin
                    n_duty = w_clamp;
                end
            end
            MODE_TICK: begin
                if (s_cur < NC3) begin
                    n_pins[s_cur[0]] = 1'b0;
                end
                if (s_nxt == NC3) begin
                    n_interval = gap;
                end else begin
                    if (s_nxt > NC3) begin
                        s_nxt = '0;
                    end
                    n_pins[s_nxt[0]] = 1'b1;
                    n_interval       = r_pw[s_nxt[0]];
                end
                n_slot    = s_nxt[1:0];
                el_sum    = r_elapsed + n_interval;
                n_elapsed = (el_sum >= r_period) ? '0 : el_sum;
            end
            MODE_NOP: begin
                n_duty = '0;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_elapsed <= '0;
            r_pw[0]   <= '0;
            r_pw[1]   <= '0;
            r_pins    <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NSTG-1];
            if (r_vld[NSTG-1]) begin
                r_slot    <= n_slot;
                r_elapsed <= n_elapsed;
                r_pins    <= n_pins;
                if ((r_ctl[7].mode == MODE_POSITION || r_ctl[7].mode == MODE_ANGLE)
                    && ch_ok) begin
                    r_pw[r_ctl[7].ch] <= w_clamp;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (en && r_vld[NSTG-1]) begin
            r_pin_mask <= n_pins;
            r_interval <= n_interval;
            r_duty     <= n_duty;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_pin_mask      = r_pin_mask;
    assign o_next_interval = r_interval;
    assign o_duty_value    = r_duty;

endmodule

// File: sv/mspg_checker.sv
`include "multichannel_servo_pulse_generator_macros.svh"

module mspg_checker
    import mspg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [MASK_W-1:0] o_pin_mask,
    input logic [TICS_W-1:0] o_next_interval,
    input logic [TICS_W-1:0] o_duty_value
);

    // a stalled result holds until transferred
    `MSPG_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_pin_mask) && $stable(o_next_interval) && $stable(o_duty_value), "stalled result changed")

    // the sequencer drives at most one servo pin at a time
    `MSPG_ASSERT_SAME(a_one_pin, o_valid, $onehot0(o_pin_mask), "more than one pin high")

    // a stored duty comes only from a set item, which reports no interval
    `MSPG_ASSERT_SAME(a_duty_no_interval, o_valid && (o_duty_value != '0), o_next_interval == '0, "duty and interval in one result")

    // reset empties the output
    `MSPG_ASSERT_RESET(a_reset_empty, !o_valid, "result valid after reset")

endmodule

bind multichannel_servo_pulse_generator mspg_checker u_mspg_checker (.*);
